[src/ufk_pkg.sv]
package ufk_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int NODE_W        = 11;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 11'd1024;

  localparam logic OP_UNITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // source of the walk pointer for the next cycle
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_A,
    CUR_B,
    CUR_MEM,
    CUR_TOP,
    CUR_JM1
  } ufk_cur_sel_t;

  typedef struct packed {
    logic         clr_step;
    logic         accept;
    ufk_cur_sel_t cur_sel;
    logic         ra_load;
    logic         r_load;
    logic         link_write;
    logic         scan_init;
    logic         scan_hit;
    logic         scan_next;
    logic         res_hit;
    logic         res_miss;
    logic         out_load;
  } ufk_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_is_query;
    logic in_unite_ok;
    logic in_query_ok;
    logic mem_is_root;
    logic cur_is_ra;
    logic cur_is_r;
    logic hit_last;
    logic j_zero;
    logic out_busy;
  } ufk_status_t;

endpackage

[src/ufk_datapath.sv]
module ufk_datapath #(
  parameter int MAX_NODES = ufk_pkg::DEF_MAX_NODES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ufk_pkg::ufk_cmd_t          cmd,
  output ufk_pkg::ufk_status_t       status,
  input  logic                       in_opcode,
  input  logic [ufk_pkg::NODE_W-1:0] in_first_node,
  input  logic [ufk_pkg::NODE_W-1:0] in_second_node,
  input  logic [ufk_pkg::NODE_W-1:0] in_rank_k,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ufk_pkg::NODE_W-1:0] cfg_node_count,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [ufk_pkg::NODE_W-1:0] out_member_node
);

  localparam int NW = ufk_pkg::NODE_W;
  localparam int IW = $clog2(MAX_NODES);
  localparam logic [IW-1:0] IDX_TOP = IW'(MAX_NODES - 1);

  logic [IW-1:0] parent_mem [MAX_NODES];
  logic [IW-1:0] mem_q_r;

  logic [NW-1:0] node_count_r;
  logic [IW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] ra_r, r_r, j_r;
  logic [NW-1:0] b_r, k_r, seen_r;
  logic [NW:0]   seen_inc;
  logic          res_found_r;
  logic [NW-1:0] res_member_r;
  logic          out_valid_r, out_found_r;
  logic [NW-1:0] out_member_r;
  logic          a_ok, b_ok;

  function automatic logic node_ok(input logic [NW-1:0] node, input logic [NW-1:0] cnt);
    node_ok = (node != '0) && (node <= cnt) && (32'(node) <= MAX_NODES);
  endfunction

  function automatic logic [IW-1:0] node_idx(input logic [NW-1:0] node);
    node_idx = IW'(node - NW'(1));
  endfunction

  assign cfg_ready = 1'b1;
  assign a_ok      = node_ok(in_first_node, node_count_r);
  assign b_ok      = node_ok(in_second_node, node_count_r);
  assign seen_inc  = {1'b0, seen_r} + (NW+1)'(1);
  assign clr_nxt   = clr_r + IW'(1);

  always_comb begin
    case (cmd.cur_sel)
      ufk_pkg::CUR_A:   cur_nxt = node_idx(in_first_node);
      ufk_pkg::CUR_B:   cur_nxt = node_idx(b_r);
      ufk_pkg::CUR_MEM: cur_nxt = mem_q_r;
      ufk_pkg::CUR_TOP: cur_nxt = IDX_TOP;
      ufk_pkg::CUR_JM1: cur_nxt = j_r - IW'(1);
      default:          cur_nxt = cur_r;
    endcase
  end

  always_comb begin
    status.clr_last    = (clr_r == IDX_TOP);
    status.in_is_query = (in_opcode == ufk_pkg::OP_QUERY);
    status.in_unite_ok = (in_opcode == ufk_pkg::OP_UNITE) && a_ok && b_ok;
    status.in_query_ok = (in_opcode == ufk_pkg::OP_QUERY) && a_ok && (in_rank_k != '0);
    status.mem_is_root = (mem_q_r == cur_r);
    status.cur_is_ra   = (cur_r == ra_r);
    status.cur_is_r    = (cur_r == r_r);
    status.hit_last    = (seen_inc == {1'b0, k_r});
    status.j_zero      = (j_r == '0);
    status.out_busy    = out_valid_r && !out_ready;
  end

  // parent table, one write port and one registered read at the walk pointer
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      parent_mem[clr_r] <= clr_r;
    end else if (cmd.link_write) begin
      parent_mem[cur_r] <= ra_r;
    end
    mem_q_r <= parent_mem[cur_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= ufk_pkg::NODE_COUNT_RST;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count_r <= cfg_node_count;
      end
      if (cmd.clr_step) begin
        clr_r <= clr_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (cmd.accept) begin
      b_r <= in_second_node;
      k_r <= in_rank_k;
    end
    if (cmd.ra_load) begin
      ra_r <= cur_r;
    end
    if (cmd.r_load) begin
      r_r <= cur_r;
    end
    if (cmd.scan_init) begin
      j_r    <= IDX_TOP;
      seen_r <= '0;
    end else begin
      if (cmd.scan_hit) begin
        seen_r <= seen_inc[NW-1:0];
      end
      if (cmd.scan_next) begin
        j_r <= j_r - IW'(1);
      end
    end
    if (cmd.res_hit) begin
      res_found_r  <= 1'b1;
      res_member_r <= NW'({1'b0, j_r} + (IW+1)'(1));
    end else if (cmd.res_miss) begin
      res_found_r  <= 1'b0;
      res_member_r <= '0;
    end
    if (cmd.out_load) begin
      out_found_r  <= res_found_r;
      out_member_r <= res_member_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_member_node = out_member_r;

endmodule

[src/ufk_ctrl.sv]
module ufk_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ufk_pkg::ufk_status_t status,
  output ufk_pkg::ufk_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_RD,
    S_WALK_CHK,
    S_PUSH
  } state_t;

  // what to do once the walk reaches a root
  typedef enum logic [1:0] {
    P_UNITE_A,
    P_UNITE_B,
    P_QUERY_ROOT,
    P_SCAN
  } purpose_t;

  state_t   state_r, state_nxt;
  purpose_t purpose_r, purpose_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.cur_sel = ufk_pkg::CUR_HOLD;
    state_nxt   = state_r;
    purpose_nxt = purpose_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.in_unite_ok) begin
            cmd.cur_sel = ufk_pkg::CUR_A;
            purpose_nxt = P_UNITE_A;
            state_nxt   = S_WALK_RD;
          end else if (status.in_query_ok) begin
            cmd.cur_sel = ufk_pkg::CUR_A;
            purpose_nxt = P_QUERY_ROOT;
            state_nxt   = S_WALK_RD;
          end else if (status.in_is_query) begin
            cmd.res_miss = 1'b1;
            state_nxt    = S_PUSH;
          end
        end
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (!status.mem_is_root) begin
          cmd.cur_sel = ufk_pkg::CUR_MEM;
          state_nxt   = S_WALK_RD;
        end else begin
          unique case (purpose_r)
            P_UNITE_A: begin
              cmd.ra_load = 1'b1;
              cmd.cur_sel = ufk_pkg::CUR_B;
              purpose_nxt = P_UNITE_B;
              state_nxt   = S_WALK_RD;
            end
            P_UNITE_B: begin
              cmd.link_write = !status.cur_is_ra;
              state_nxt      = S_IDLE;
            end
            P_QUERY_ROOT: begin
              cmd.r_load    = 1'b1;
              cmd.scan_init = 1'b1;
              cmd.cur_sel   = ufk_pkg::CUR_TOP;
              purpose_nxt   = P_SCAN;
              state_nxt     = S_WALK_RD;
            end
            P_SCAN: begin
              cmd.scan_hit = status.cur_is_r;
              if (status.cur_is_r && status.hit_last) begin
                cmd.res_hit = 1'b1;
                state_nxt   = S_PUSH;
              end else if (status.j_zero) begin
                cmd.res_miss = 1'b1;
                state_nxt    = S_PUSH;
              end else begin
                cmd.scan_next = 1'b1;
                cmd.cur_sel   = ufk_pkg::CUR_JM1;
                state_nxt     = S_WALK_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_PUSH: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      purpose_r <= P_UNITE_A;
    end else begin
      state_r   <= state_nxt;
      purpose_r <= purpose_nxt;
    end
  end

endmodule

[src/union_find_kth_largest_unit.sv]
// Disjoint-set table over nodes 1..node_count with a k-th largest member query.
// Input channel (in_valid/in_ready): opcode 0 unites first_node and second_node,
// giving no result; opcode 1 queries the component of first_node for rank_k.
// Result channel (out_valid/out_ready): found and member_node, one beat per query.
// Config channel (cfg_valid/cfg_ready): writes node_count, always ready; write
// only while the block is idle.
// Operation: every parent lookup is a registered table read, so each link
// followed passes through a read state and a check state. A unite walks a to
// its root, then b. A query walks a, then scans from node MAX_NODES down to the
// k-th hit, one root walk per scanned node, then loads the output register. A
// full scan runs longer as trees grow deeper.
// Reset: a clearing pass over all MAX_NODES entries sets every node as its own
// root; in_ready stays low during it. node_count returns to 1024.
// Stall: a finished result sits in the output register; a following unite is
// taken meanwhile, while a query waits at its end until the register frees.
module union_find_kth_largest_unit #(
  parameter int MAX_NODES = ufk_pkg::DEF_MAX_NODES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_opcode,
  input  logic [ufk_pkg::NODE_W-1:0] in_first_node,
  input  logic [ufk_pkg::NODE_W-1:0] in_second_node,
  input  logic [ufk_pkg::NODE_W-1:0] in_rank_k,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_found,
  output logic [ufk_pkg::NODE_W-1:0] out_member_node,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ufk_pkg::NODE_W-1:0] cfg_node_count
);

  ufk_pkg::ufk_cmd_t    cmd;
  ufk_pkg::ufk_status_t status;

  ufk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ufk_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_opcode       (in_opcode),
    .in_first_node   (in_first_node),
    .in_second_node  (in_second_node),
    .in_rank_k       (in_rank_k),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_node_count  (cfg_node_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_member_node (out_member_node)
  );

endmodule
